FILE: rtl/gaze_error_deadzone_hysteresis_core_defines.svh
// Assertion macros shared by the gaze error deadzone core
`ifndef GAZE_ERROR_DEADZONE_HYSTERESIS_CORE_DEFINES_SVH
`define GAZE_ERROR_DEADZONE_HYSTERESIS_CORE_DEFINES_SVH

// check the consequent in the same cycle as the antecedent
`define GEDH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gedh: same-cycle check failed");

// check the consequent in the cycle after the antecedent
`define GEDH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gedh: next-cycle check failed");

`endif

FILE: rtl/gedh_pkg.sv
// Shared types and constants of the gaze error deadzone core
package gedh_pkg;

    localparam int THR_W      = 23;
    localparam int TIME_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_RADIUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DWELL      = 2'd2;

    localparam logic [THR_W-1:0]  ZONE_RADIUS_RST    = 23'd20972;
    localparam logic [THR_W-1:0]  EXIT_THRESHOLD_RST = 23'd125829;
    localparam logic [TIME_W-1:0] MIN_DWELL_RST      = 32'd500000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_THRESH,
        ST_COMPARE,
        ST_DECIDE,
        ST_ROOT,
        ST_SCALE,
        ST_LOAD,
        ST_DIVIDE,
        ST_FINISH,
        ST_OUTPUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic square;
        logic thresh;
        logic compare;
        logic hold;
        logic load_timer;
        logic root_init;
        logic root_step;
        logic scale;
        logic div_load;
        logic div_step;
        logic finish;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic above_r;
        logic above_e;
        logic dwell_zero;
        logic dwell_met;
    } t_status;

endpackage

FILE: rtl/gedh_ctrl.sv
// Sequencer and zone/timer flags of the gaze error deadzone core
`include "gaze_error_deadzone_hysteresis_core_defines.svh"

module gedh_ctrl #(
    parameter int COMP_WIDTH = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output gedh_pkg::t_cmd   o_cmd,
    input  gedh_pkg::t_status i_status
);
    import gedh_pkg::*;

    localparam int NUM_W = COMP_WIDTH + THR_W;
    localparam int CNT_W = $clog2(NUM_W);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_in_zone, n_in_zone;
    logic              r_timer_armed, n_timer_armed;
    logic              r_out_valid, n_out_valid;
    t_cmd              cmd;
    logic              exit_hi, stay_out, enough;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cnt         <= '0;
            r_in_zone     <= 1'b0;
            r_timer_armed <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cnt         <= n_cnt;
            r_in_zone     <= n_in_zone;
            r_timer_armed <= n_timer_armed;
            r_out_valid   <= n_out_valid;
        end
    end

    assign exit_hi  = r_in_zone && i_status.above_e;
    assign stay_out = !r_in_zone && i_status.above_r;
    assign enough   = i_status.dwell_zero || (r_timer_armed && i_status.dwell_met);

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_in_zone     = r_in_zone;
        n_timer_armed = r_timer_armed;
        cmd           = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                n_state    = ST_THRESH;
            end
            ST_THRESH: begin
                cmd.thresh = 1'b1;
                n_state    = ST_COMPARE;
            end
            ST_COMPARE: begin
                cmd.compare = 1'b1;
                n_state     = ST_DECIDE;
            end
            ST_DECIDE: begin
                if ((exit_hi && enough) || stay_out) begin
                    n_in_zone     = 1'b0;
                    n_timer_armed = 1'b0;
                    cmd.root_init = 1'b1;
                    n_cnt         = CNT_W'(COMP_WIDTH - 1);
                    n_state       = ST_ROOT;
                end else begin
                    n_in_zone = 1'b1;
                    if (exit_hi && !r_timer_armed) begin
                        n_timer_armed  = 1'b1;
                        cmd.load_timer = 1'b1;
                    end
                    if (!exit_hi) begin
                        n_timer_armed = 1'b0;
                    end
                    cmd.hold = 1'b1;
                    n_state  = ST_OUTPUT;
                end
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_SCALE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_SCALE: begin
                cmd.scale = 1'b1;
                n_state   = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.div_load = 1'b1;
                n_cnt        = CNT_W'(NUM_W - 1);
                n_state      = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_FINISH;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                n_state    = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.load_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign n_out_valid = cmd.load_out || (r_out_valid && i_out_stall);
    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    `GEDH_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, (r_state == ST_IDLE) && i_in_valid, r_state == ST_SQUARE)
    `GEDH_ASSERT_NOW(a_armed_in_zone, i_clk, i_rst_n, r_timer_armed, r_in_zone)
    `GEDH_ASSERT_NOW(a_root_left_zone, i_clk, i_rst_n, r_state == ST_ROOT, !r_in_zone && !r_timer_armed)
    `GEDH_ASSERT_NOW(a_beat_from_output, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == ST_OUTPUT)

endmodule

FILE: rtl/gedh_datapath.sv
// Squares, thresholds, bit-serial root, two-lane divider and result registers
module gedh_datapath #(
    parameter int COMP_WIDTH = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gedh_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gedh_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic signed [COMP_WIDTH-1:0]        i_err_x,
    input  logic signed [COMP_WIDTH-1:0]        i_err_y,
    input  logic [gedh_pkg::TIME_W-1:0]         i_now_us,
    input  gedh_pkg::t_cmd                      i_cmd,
    output gedh_pkg::t_status                   o_status,
    output logic signed [COMP_WIDTH-1:0]        o_out_x,
    output logic signed [COMP_WIDTH-1:0]        o_out_y,
    output logic                                o_zone_active
);
    import gedh_pkg::*;

    localparam int CW  = COMP_WIDTH;
    localparam int MW  = (CW > THR_W) ? CW : THR_W;
    localparam int PW  = 2 * MW;
    localparam int SW  = 2 * CW;
    localparam int NW  = CW + THR_W;
    localparam int RSW = NW + 2;

    logic [THR_W-1:0]  r_zone_radius;
    logic [THR_W-1:0]  r_exit_threshold;
    logic [TIME_W-1:0] r_min_dwell;
    logic [TIME_W-1:0] r_timer_start;

    logic [CW-1:0]     r_x, r_y;
    logic [TIME_W-1:0] r_now;
    logic [PW-1:0]     r_p [2];
    logic [SW-1:0]     r_sq;
    logic              r_above_r, r_above_e, r_dwell_met;
    logic [CW+1:0]     r_rem_root;
    logic [CW-1:0]     r_root;
    logic [NW-1:0]     r_num [2];
    logic [CW:0]       r_drem [2];
    logic [CW-1:0]     r_res_x, r_res_y;
    logic              r_res_zone;
    logic [CW-1:0]     r_out_x, r_out_y;
    logic              r_out_zone;

    logic [CW-1:0]     comp [2];
    logic [CW-1:0]     mag [2];
    logic [MW-1:0]     op_a [2];
    logic [MW-1:0]     op_b [2];
    logic [PW-1:0]     prod [2];
    logic [TIME_W-1:0] elapsed;
    logic [CW+1:0]     rem_sh, trial;
    logic              root_ge;
    logic [CW:0]       drem_sh [2];
    logic              div_ge [2];
    logic [RSW-1:0]    cext [2];
    logic [RSW-1:0]    qext [2];
    logic [RSW-1:0]    diff [2];
    logic [RSW-CW:0]   diff_hi [2];
    logic [CW-1:0]     sat [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_radius    <= ZONE_RADIUS_RST;
            r_exit_threshold <= EXIT_THRESHOLD_RST;
            r_min_dwell      <= MIN_DWELL_RST;
            r_timer_start    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ZONE_RADIUS:    r_zone_radius    <= i_cfg_data[THR_W-1:0];
                    CFG_EXIT_THRESHOLD: r_exit_threshold <= i_cfg_data[THR_W-1:0];
                    CFG_MIN_DWELL:      r_min_dwell      <= i_cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_timer) begin
                r_timer_start <= r_now;
            end
        end
    end

    always_comb begin
        comp[0] = r_x;
        comp[1] = r_y;
        for (int i = 0; i < 2; i++) begin
            mag[i]  = comp[i][CW-1] ? (~comp[i] + 1'b1) : comp[i];
            op_a[i] = MW'(mag[i]);
            op_b[i] = MW'(mag[i]);
            if (i_cmd.scale) begin
                op_b[i] = MW'(r_zone_radius);
            end
        end
        if (i_cmd.thresh) begin
            op_a[0] = MW'(r_zone_radius);
            op_b[0] = MW'(r_zone_radius);
            op_a[1] = MW'(r_exit_threshold);
            op_b[1] = MW'(r_exit_threshold);
        end
        for (int i = 0; i < 2; i++) begin
            prod[i] = PW'(op_a[i]) * PW'(op_b[i]);
        end
    end

    assign elapsed = r_now - r_timer_start;

    assign rem_sh  = {r_rem_root[CW-1:0], r_sq[SW-1:SW-2]};
    assign trial   = {r_root, 2'b01};
    assign root_ge = (rem_sh >= trial);

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            drem_sh[i] = {r_drem[i][CW-1:0], r_num[i][NW-1]};
            div_ge[i]  = (drem_sh[i] >= {1'b0, r_root});
            cext[i]    = {{(RSW-CW){comp[i][CW-1]}}, comp[i]};
            qext[i]    = {2'b00, r_num[i]};
            diff[i]    = comp[i][CW-1] ? (cext[i] + qext[i]) : (cext[i] - qext[i]);
            diff_hi[i] = diff[i][RSW-1:CW-1];
            if ((&diff_hi[i]) || !(|diff_hi[i])) begin
                sat[i] = diff[i][CW-1:0];
            end else if (diff[i][RSW-1]) begin
                sat[i] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                sat[i] = {1'b0, {(CW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x   <= i_err_x;
            r_y   <= i_err_y;
            r_now <= i_now_us;
        end
        if (i_cmd.square || i_cmd.thresh || i_cmd.scale) begin
            r_p[0] <= prod[0];
            r_p[1] <= prod[1];
        end
        if (i_cmd.thresh) begin
            r_sq <= r_p[0][SW-1:0] + r_p[1][SW-1:0];
        end else if (i_cmd.root_step) begin
            r_sq <= {r_sq[SW-3:0], 2'b00};
        end
        if (i_cmd.compare) begin
            r_above_r   <= (PW'(r_sq) > r_p[0]);
            r_above_e   <= (PW'(r_sq) > r_p[1]);
            r_dwell_met <= (elapsed >= r_min_dwell);
        end
        if (i_cmd.root_init) begin
            r_rem_root <= '0;
            r_root     <= '0;
        end else if (i_cmd.root_step) begin
            r_rem_root <= root_ge ? (rem_sh - trial) : rem_sh;
            r_root     <= {r_root[CW-2:0], root_ge};
        end
        for (int i = 0; i < 2; i++) begin
            if (i_cmd.div_load) begin
                r_num[i]  <= r_p[i][NW-1:0] + NW'(r_root[CW-1:1]);
                r_drem[i] <= '0;
            end else if (i_cmd.div_step) begin
                r_num[i]  <= {r_num[i][NW-2:0], div_ge[i]};
                r_drem[i] <= div_ge[i] ? (drem_sh[i] - {1'b0, r_root}) : drem_sh[i];
            end
        end
        if (i_cmd.hold) begin
            r_res_x    <= '0;
            r_res_y    <= '0;
            r_res_zone <= 1'b1;
        end else if (i_cmd.finish) begin
            r_res_x    <= sat[0];
            r_res_y    <= sat[1];
            r_res_zone <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out_x    <= r_res_x;
            r_out_y    <= r_res_y;
            r_out_zone <= r_res_zone;
        end
    end

    assign o_status.above_r    = r_above_r;
    assign o_status.above_e    = r_above_e;
    assign o_status.dwell_zero = (r_min_dwell == '0);
    assign o_status.dwell_met  = r_dwell_met;

    assign o_out_x       = r_out_x;
    assign o_out_y       = r_out_y;
    assign o_zone_active = r_out_zone;

endmodule

FILE: rtl/gaze_error_deadzone_hysteresis_core.sv
// Radial deadzone with hysteresis and dwell time: top level
// The shrunk path runs through the bit-serial square root and the restoring divider,
// both lanes side by side; one item at a time, next beat accepted in the cycle after
// the result loads. Synchronous active-low reset clears zone, timer and handshake
// state and restores register defaults.
module gaze_error_deadzone_hysteresis_core #(
    parameter int COMP_WIDTH = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [COMP_WIDTH-1:0]    i_err_x,
    input  logic signed [COMP_WIDTH-1:0]    i_err_y,
    input  logic [gedh_pkg::TIME_W-1:0]     i_now_us,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [COMP_WIDTH-1:0]    o_out_x,
    output logic signed [COMP_WIDTH-1:0]    o_out_y,
    output logic                            o_zone_active,
    input  logic                            i_cfg_we,
    input  logic [gedh_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gedh_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gedh_pkg::*;

    t_cmd    cmd;
    t_status status;

    gedh_ctrl #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    gedh_datapath #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_err_x       (i_err_x),
        .i_err_y       (i_err_y),
        .i_now_us      (i_now_us),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_zone_active (o_zone_active)
    );

endmodule
